@@ rtl/bptc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared types and constants for the barometric temperature and pressure
// compensation pipeline.
// ----------------------------------------------------------------------------
package bptc_pkg;

  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int IDX_W   = 3;
  localparam int TEMP_W  = 19;
  localparam int DT_W    = 25;
  localparam int PROD_W  = 42;
  localparam int DSQ_W   = 50;
  localparam int DTSQ_W  = 18;
  localparam int ACC_W   = 40;
  localparam int P_W     = 32;

  localparam logic [IDX_W-1:0] REG_C1 = 3'd0;
  localparam logic [IDX_W-1:0] REG_C2 = 3'd1;
  localparam logic [IDX_W-1:0] REG_C3 = 3'd2;
  localparam logic [IDX_W-1:0] REG_C4 = 3'd3;
  localparam logic [IDX_W-1:0] REG_C5 = 3'd4;
  localparam logic [IDX_W-1:0] REG_C6 = 3'd5;

  localparam logic signed [TEMP_W-1:0] TEMP_BASE   = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] COLD_OFFSET = 19'sd3500;
  localparam logic signed [TEMP_W-1:0] COLD_LIMIT  = -19'sd3500;

  localparam logic signed [P_W-1:0] P_MAX = {1'b0, {(P_W-1){1'b1}}};
  localparam logic signed [P_W-1:0] P_MIN = {1'b1, {(P_W-1){1'b0}}};

  typedef struct packed {
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
    logic [COEF_W-1:0] c3;
    logic [COEF_W-1:0] c4;
    logic [COEF_W-1:0] c5;
    logic [COEF_W-1:0] c6;
  } coeff_t;

  typedef struct packed {
    logic                     valid;
    logic signed [TEMP_W-1:0] temp;
    logic signed [TEMP_W-1:0] q;
    logic signed [ACC_W-1:0]  off;
    logic signed [ACC_W-1:0]  sens;
    logic [DTSQ_W-1:0]        dtsq;
    logic [RAW_W-1:0]         d1;
  } first_t;

  typedef struct packed {
    logic                     valid;
    logic signed [TEMP_W-1:0] temp;
    logic signed [ACC_W-1:0]  off;
    logic signed [ACC_W-1:0]  sens;
    logic [RAW_W-1:0]         d1;
  } second_t;

endpackage
`default_nettype wire

@@ rtl/bptc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bptc_front
// Temperature difference, first-order products and first-order temperature,
// offset and sensitivity over three register stages.
// ----------------------------------------------------------------------------
module bptc_front (
  input  wire                          clk,
  input  wire                          rst,
  input  bptc_pkg::coeff_t             coeff,
  input  wire                          in_valid,
  input  wire [bptc_pkg::RAW_W-1:0]    raw_temperature,
  input  wire [bptc_pkg::RAW_W-1:0]    raw_pressure,
  output bptc_pkg::first_t             res
);
  import bptc_pkg::*;

  logic                     v1, v2;
  logic signed [DT_W-1:0]   dt1;
  logic [RAW_W-1:0]         d1_1, d1_2;
  logic signed [PROD_W-1:0] p6, p4, p3;
  logic signed [DSQ_W-1:0]  pdd;
  logic signed [DT_W-1:0]   dt_next;
  logic signed [PROD_W-1:0] p6_next, p4_next, p3_next;
  logic signed [DSQ_W-1:0]  pdd_next;
  first_t                   res_next;

  assign dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, coeff.c5, 8'b0});

  assign p6_next  = dt1 * $signed({1'b0, coeff.c6});
  assign p4_next  = dt1 * $signed({1'b0, coeff.c4});
  assign p3_next  = dt1 * $signed({1'b0, coeff.c3});
  assign pdd_next = dt1 * dt1;

  always_comb begin
    res_next.valid = v2 & ~rst;
    res_next.q     = TEMP_W'(p6 >>> 23);
    res_next.temp  = TEMP_BASE + TEMP_W'(p6 >>> 23);
    res_next.off   = ACC_W'($signed({1'b0, coeff.c2, 16'b0})) + ACC_W'(p4 >>> 7);
    res_next.sens  = ACC_W'($signed({1'b0, coeff.c1, 15'b0})) + ACC_W'(p3 >>> 8);
    res_next.dtsq  = DTSQ_W'(pdd >>> 31);
    res_next.d1    = d1_2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    dt1  <= dt_next;
    d1_1 <= raw_pressure;
    p6   <= p6_next;
    p4   <= p4_next;
    p3   <= p3_next;
    pdd  <= pdd_next;
    d1_2 <= d1_1;
    res  <= res_next;
  end

endmodule
`default_nettype wire

@@ rtl/bptc_second.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bptc_second
// Second-order low-temperature corrections: squares, correction terms, and
// their subtraction from temperature, offset and sensitivity.
// ----------------------------------------------------------------------------
module bptc_second (
  input  wire                clk,
  input  wire                rst,
  input  bptc_pkg::first_t   din,
  input  wire                din_valid,
  output bptc_pkg::second_t  res
);
  import bptc_pkg::*;

  logic                       v4, v5;
  logic signed [2*TEMP_W-1:0] tt, uu;
  logic                       low4, cold4;
  logic signed [TEMP_W-1:0]   temp4, temp5;
  logic signed [ACC_W-1:0]    off4, sens4, off5, sens5;
  logic [DTSQ_W-1:0]          dtsq4;
  logic [RAW_W-1:0]           d1_4, d1_5;
  logic [ACC_W-1:0]           offc, sensc;

  logic signed [TEMP_W-1:0]   u_next;
  logic [ACC_W-1:0]           tt_u, uu_u, d_five;
  logic [ACC_W-1:0]           offc_next, sensc_next;
  logic signed [TEMP_W-1:0]   temp5_next;
  second_t                    res_next;

  assign u_next = din.q + COLD_OFFSET;

  always_comb begin
    tt_u   = ACC_W'(tt);
    uu_u   = ACC_W'(uu);
    d_five = (tt_u << 2) + tt_u;
    offc_next  = (low4 ? (d_five >> 1) : '0)
               + (cold4 ? ((uu_u << 3) - uu_u) : '0);
    sensc_next = (low4 ? (d_five >> 2) : '0)
               + (cold4 ? (((uu_u << 3) + (uu_u << 1) + uu_u) >> 1) : '0);
    temp5_next = low4 ? (temp4 - $signed({1'b0, dtsq4})) : temp4;
  end

  always_comb begin
    res_next.valid = v5 & ~rst;
    res_next.temp  = temp5;
    res_next.off   = off5 - $signed(offc);
    res_next.sens  = sens5 - $signed(sensc);
    res_next.d1    = d1_5;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v4 <= din_valid;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    tt    <= din.q * din.q;
    uu    <= u_next * u_next;
    low4  <= din.q[TEMP_W-1];
    cold4 <= din.q < COLD_LIMIT;
    temp4 <= din.temp;
    off4  <= din.off;
    sens4 <= din.sens;
    dtsq4 <= din.dtsq;
    d1_4  <= din.d1;
    offc  <= offc_next;
    sensc <= sensc_next;
    temp5 <= temp5_next;
    off5  <= off4;
    sens5 <= sens4;
    d1_5  <= d1_4;
    res   <= res_next;
  end

endmodule
`default_nettype wire

@@ rtl/bptc_press.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bptc_press
// Pressure from raw pressure and sensitivity: split product, shift, offset
// subtraction and clamp to the signed 32-bit range.
// ----------------------------------------------------------------------------
module bptc_press (
  input  wire                                 clk,
  input  wire                                 rst,
  input  bptc_pkg::second_t                   din,
  input  wire                                 din_valid,
  output logic                                done,
  output logic signed [bptc_pkg::TEMP_W-1:0]  temperature_centideg,
  output logic signed [bptc_pkg::P_W-1:0]     pressure_pascal
);
  import bptc_pkg::*;

  localparam int SPLIT = ACC_W / 2;
  localparam int PH_W  = RAW_W + 1 + (ACC_W - SPLIT);
  localparam int PL_W  = RAW_W + SPLIT;
  localparam int SH_W  = 64 - 21;
  localparam int DF_W  = SH_W + 1;

  logic                     v7, v8;
  logic signed [PH_W-1:0]   ph;
  logic [PL_W-1:0]          pl;
  logic signed [ACC_W-1:0]  off7, off8;
  logic signed [TEMP_W-1:0] temp7, temp8;
  logic signed [SH_W-1:0]   psh;
  logic signed [63:0]       prod;
  logic signed [DF_W-1:0]   diff, pw;
  logic signed [P_W-1:0]    p_next;

  assign prod = (64'(ph) <<< SPLIT) + 64'($signed({1'b0, pl}));

  always_comb begin
    diff = DF_W'(psh) - DF_W'(off8);
    pw   = diff >>> 15;
    if (pw > DF_W'(P_MAX)) begin
      p_next = P_MAX;
    end else if (pw < DF_W'(P_MIN)) begin
      p_next = P_MIN;
    end else begin
      p_next = P_W'(pw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7   <= 1'b0;
      v8   <= 1'b0;
      done <= 1'b0;
    end else begin
      v7   <= din_valid;
      v8   <= v7;
      done <= v8;
    end
  end

  always_ff @(posedge clk) begin
    ph    <= $signed({1'b0, din.d1}) * $signed(din.sens[ACC_W-1:SPLIT]);
    pl    <= din.d1 * din.sens[SPLIT-1:0];
    off7  <= din.off;
    temp7 <= din.temp;
    psh   <= SH_W'(prod >>> 21);
    off8  <= off7;
    temp8 <= temp7;
    temperature_centideg <= temp8;
    pressure_pascal      <= p_next;
  end

endmodule
`default_nettype wire

@@ rtl/baro_temp_pressure_compensation_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_top
// Second-order compensation of raw barometer temperature and pressure
// conversions with six calibration coefficients.
//
//   channel   signals                                   transfer
//   input     start, busy, raw_temperature, raw_pressure start & !busy
//   result    done, temperature_centideg, pressure_pascal done, one cycle
//   config    cfg_write, cfg_index, cfg_data             cfg_write
//
// Nine register stages; an item enters every cycle while busy is low. The
// final 64-bit product, raw pressure times sensitivity, is split into two
// partial products across two stages.
// busy is high only during reset. Synchronous reset clears the valid bits and
// the coefficients. The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_top (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  output logic                                busy,
  input  wire [bptc_pkg::RAW_W-1:0]           raw_temperature,
  input  wire [bptc_pkg::RAW_W-1:0]           raw_pressure,
  output logic                                done,
  output logic signed [bptc_pkg::TEMP_W-1:0]  temperature_centideg,
  output logic signed [bptc_pkg::P_W-1:0]     pressure_pascal,
  input  wire                                 cfg_write,
  input  wire [bptc_pkg::IDX_W-1:0]           cfg_index,
  input  wire [bptc_pkg::COEF_W-1:0]          cfg_data
);
  import bptc_pkg::*;

  coeff_t  coeff;
  first_t  first_res;
  second_t second_res;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_C1: begin
          coeff.c1 <= cfg_data;
        end
        REG_C2: begin
          coeff.c2 <= cfg_data;
        end
        REG_C3: begin
          coeff.c3 <= cfg_data;
        end
        REG_C4: begin
          coeff.c4 <= cfg_data;
        end
        REG_C5: begin
          coeff.c5 <= cfg_data;
        end
        REG_C6: begin
          coeff.c6 <= cfg_data;
        end
        default: begin
          coeff <= coeff;
        end
      endcase
    end
  end

  bptc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .coeff           (coeff),
    .in_valid        (start & ~busy),
    .raw_temperature (raw_temperature),
    .raw_pressure    (raw_pressure),
    .res             (first_res)
  );

  bptc_second u_second (
    .clk       (clk),
    .rst       (rst),
    .din       (first_res),
    .din_valid (first_res.valid),
    .res       (second_res)
  );

  bptc_press u_press (
    .clk                  (clk),
    .rst                  (rst),
    .din                  (second_res),
    .din_valid            (second_res.valid),
    .done                 (done),
    .temperature_centideg (temperature_centideg),
    .pressure_pascal      (pressure_pascal)
  );

endmodule
`default_nettype wire
